// File: sv/vbc_pkg.sv
// ----------------------------------------------------------------------------
// vbc_pkg
// Shared types, constants and byte classification helpers for the byte
// cipher: request kinds, byte classes, queue entry layout and code points.
// ----------------------------------------------------------------------------
`default_nettype none

package vbc_pkg;

    // Key store sizing
    localparam int STORE_SLOTS       = 32;
    localparam int KEY_DEPTH_DEFAULT = 32;
    localparam int KEY_W             = 5;
    localparam int LEN_W             = 6;

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic REG_KEY_LEN = 1'b0;
    localparam logic [LEN_W-1:0] KEY_LEN_RESET = 6'd1;

    // Request kinds carried on tuser
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_KEY  = 1'b1;

    // Code points of the single-byte Cyrillic page and Latin letters
    localparam logic [7:0] YO_UPPER      = 8'd168;
    localparam logic [7:0] YO_LOWER      = 8'd184;
    localparam logic [7:0] YO_UPPER_FOLD = 8'd197;
    localparam logic [7:0] YO_LOWER_FOLD = 8'd229;
    localparam logic [7:0] CYR_FIRST     = 8'd192;
    localparam logic [7:0] CYR_UPPER_END = 8'd223;
    localparam logic [7:0] LAT_UPPER_LO  = 8'd65;
    localparam logic [7:0] LAT_UPPER_HI  = 8'd90;
    localparam logic [7:0] LAT_LOWER_LO  = 8'd97;
    localparam logic [7:0] LAT_LOWER_HI  = 8'd122;
    localparam logic [8:0] CYR_LOWER_END = 9'd255;
    localparam logic [8:0] CYR_WRAP      = 9'd32;
    localparam logic [8:0] LAT_WRAP      = 9'd26;

    // Class of a plaintext byte after yo folding
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_CYR_UPPER,
        CLS_CYR_LOWER,
        CLS_LAT_UPPER,
        CLS_LAT_LOWER
    } byte_class_t;

    // One entry of the queue between front and back
    typedef struct packed {
        logic              is_key;
        byte_class_t       cls;
        logic [7:0]        data;
        logic [KEY_W-1:0]  key_index;
        logic [KEY_W-1:0]  key_value;
    } q_item_t;

    // True for any byte the cipher treats as a letter
    function automatic logic is_letter(input logic [7:0] b);
        logic cyr;
        logic lat;
        cyr = (b >= CYR_FIRST) || (b == YO_UPPER) || (b == YO_LOWER);
        lat = ((b >= LAT_UPPER_LO) && (b <= LAT_UPPER_HI)) ||
              ((b >= LAT_LOWER_LO) && (b <= LAT_LOWER_HI));
        return cyr || lat;
    endfunction

endpackage

`default_nettype wire

// File: sv/vbc_front.sv
// ----------------------------------------------------------------------------
// vbc_front
// Front part: unpacks an incoming request, folds the two yo letters into
// their plain counterparts and tags the byte with its letter class.
// ----------------------------------------------------------------------------
`default_nettype none

module vbc_front (
    input  wire logic                   req_type,
    input  wire logic [7:0]             data_byte,
    input  wire logic [vbc_pkg::KEY_W-1:0] key_index,
    input  wire logic [vbc_pkg::KEY_W-1:0] key_value,
    output vbc_pkg::q_item_t            item
);
    import vbc_pkg::*;

    logic [7:0]  folded;
    byte_class_t cls;

    // Fold yo letters and classify the resulting byte
    always_comb
    begin
        folded = data_byte;
        if (data_byte == YO_UPPER)
        begin
            folded = YO_UPPER_FOLD;
        end
        else if (data_byte == YO_LOWER)
        begin
            folded = YO_LOWER_FOLD;
        end

        if (folded > CYR_UPPER_END)
        begin
            cls = CLS_CYR_LOWER;
        end
        else if (folded >= CYR_FIRST)
        begin
            cls = CLS_CYR_UPPER;
        end
        else if ((folded >= LAT_UPPER_LO) && (folded <= LAT_UPPER_HI))
        begin
            cls = CLS_LAT_UPPER;
        end
        else if ((folded >= LAT_LOWER_LO) && (folded <= LAT_LOWER_HI))
        begin
            cls = CLS_LAT_LOWER;
        end
        else
        begin
            cls = CLS_OTHER;
        end
    end

    // Build the queue entry
    always_comb
    begin
        item.is_key    = (req_type == REQ_KEY);
        item.cls       = cls;
        item.data      = folded;
        item.key_index = key_index;
        item.key_value = key_value;
    end

endmodule

`default_nettype wire

// File: sv/vbc_queue.sv
// ----------------------------------------------------------------------------
// vbc_queue
// Short register queue between front and back. Its ready depends only on
// its own fill level, so the two sides stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module vbc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vbc_pkg::q_item_t  in_item,
    output logic                   out_valid,
    input  wire logic              out_pop,
    output vbc_pkg::q_item_t       out_item
);
    import vbc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_item_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    // Pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: sv/vbc_back.sv
// ----------------------------------------------------------------------------
// vbc_back
// Back part: holds the key store and key position, writes key entries,
// shifts classified bytes and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vbc_back #(
    parameter int KEY_DEPTH = vbc_pkg::KEY_DEPTH_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [vbc_pkg::LEN_W-1:0] key_len,
    input  wire logic                      item_valid,
    output logic                           item_pop,
    input  wire vbc_pkg::q_item_t          item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     out_byte
);
    import vbc_pkg::*;

    // Entries actually present in the store
    localparam int SLOTS  = (KEY_DEPTH < STORE_SLOTS) ? KEY_DEPTH : STORE_SLOTS;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [KEY_W-1:0] key_store_reg [SLOTS];
    logic [KEY_W-1:0] key_pos_reg;
    logic [KEY_W-1:0] key_pos_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;

    logic [LEN_W-1:0] len_eff;
    logic [LEN_W-1:0] last_pos;
    logic [KEY_W-1:0] shift;
    logic [8:0]       sum;
    logic [7:0]       cipher;
    logic             key_wr;
    logic             data_go;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // A key write always proceeds; a data byte needs room in the output register
    assign item_pop = item_valid && (item.is_key || !out_valid_reg || out_ready);
    assign key_wr   = item_pop && item.is_key;
    assign data_go  = item_pop && !item.is_key;

    // Length in use, clamped to one and to the store size
    always_comb
    begin
        if (key_len == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (key_len > LEN_W'(SLOTS))
        begin
            len_eff = LEN_W'(SLOTS);
        end
        else
        begin
            len_eff = key_len;
        end
        last_pos = len_eff - 1'b1;
    end

    // Key lookup; positions past the store read as zero
    always_comb
    begin
        if ({1'b0, key_pos_reg} < LEN_W'(SLOTS))
        begin
            shift = key_store_reg[key_pos_reg[IDX_W-1:0]];
        end
        else
        begin
            shift = '0;
        end
    end

    // Shift with one wrap inside the letter's range
    always_comb
    begin
        sum = {1'b0, item.data} + 9'(shift);
        case (item.cls)
            CLS_CYR_UPPER: cipher = (sum > {1'b0, CYR_UPPER_END}) ? 8'(sum - CYR_WRAP) : sum[7:0];
            CLS_CYR_LOWER: cipher = (sum > CYR_LOWER_END) ? 8'(sum - CYR_WRAP) : sum[7:0];
            CLS_LAT_UPPER: cipher = (sum > {1'b0, LAT_UPPER_HI}) ? 8'(sum - LAT_WRAP) : sum[7:0];
            CLS_LAT_LOWER: cipher = (sum > {1'b0, LAT_LOWER_HI}) ? 8'(sum - LAT_WRAP) : sum[7:0];
            default:       cipher = item.data;
        endcase
    end

    // Position advance and output register
    always_comb
    begin
        key_pos_next   = key_pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        if (data_go)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cipher;
            if (is_letter(cipher) && ({1'b0, key_pos_reg} != last_pos))
            begin
                key_pos_next = key_pos_reg + 1'b1;
            end
            else
            begin
                key_pos_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_pos_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_pos_reg   <= key_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    // Key store write; indexes past the store are dropped
    always_ff @(posedge clk)
    begin
        if (key_wr && ({1'b0, item.key_index} < LEN_W'(SLOTS)))
        begin
            key_store_reg[item.key_index[IDX_W-1:0]] <= item.key_value;
        end
    end

endmodule

`default_nettype wire

// File: sv/vigenere_byte_cipher.sv
// ----------------------------------------------------------------------------
// vigenere_byte_cipher
// Byte-stream Vigenere encryptor over a single-byte Cyrillic page and
// Latin letters, with a writable key store and an APB length register.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: req_type; tdata: data_byte, key_index, key_value
//   m_axis    out        tdata: out_byte (one per data request)
//   apb       in/out     register 0 at address 0: key length in use
//
// One request per cycle is sustained while m_axis does not stall; the key
// position loop in the back part closes combinationally. A data byte passes
// the queue and the output register before it appears on m_axis. The two-entry
// queue keeps s_axis_tready high while the output stalls until the queue is
// full. Reset clears key position, queue and output state and sets the key
// length to 1; the key store holds no defined value until written.
// ----------------------------------------------------------------------------
`default_nettype none

module vigenere_byte_cipher #(
    parameter int KEY_DEPTH = vbc_pkg::KEY_DEPTH_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [7:0] data_byte, [12:8] key_index,
                                            // [17:13] key_value, [23:18] zero
    input  wire logic        s_axis_tuser,  // [0] req_type
    // Output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import vbc_pkg::*;

    logic [LEN_W-1:0] key_len_reg;
    logic [LEN_W-1:0] key_len_next;
    q_item_t          front_item;
    q_item_t          head_item;
    logic             head_valid;
    logic             head_pop;
    logic             reg_sel;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_KEY_LEN);
    assign prdata  = reg_sel ? 32'(key_len_reg) : '0;

    always_comb
    begin
        key_len_next = key_len_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            key_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= KEY_LEN_RESET;
        end
        else
        begin
            key_len_reg <= key_len_next;
        end
    end

    // Front part: classification
    vbc_front u_front (
        .req_type  (s_axis_tuser),
        .data_byte (s_axis_tdata[7:0]),
        .key_index (s_axis_tdata[12:8]),
        .key_value (s_axis_tdata[17:13]),
        .item      (front_item)
    );

    // Queue between front and back
    vbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (front_item),
        .out_valid (head_valid),
        .out_pop   (head_pop),
        .out_item  (head_item)
    );

    // Back part: key store, shift and output register
    vbc_back #(
        .KEY_DEPTH (KEY_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_len    (key_len_reg),
        .item_valid (head_valid),
        .item_pop   (head_pop),
        .item       (head_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata)
    );

endmodule

`default_nettype wire
